// ===== rtl/snell_refraction_vector_macros.svh =====
// Assertion macros for the refraction block checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SNELL_REFRACTION_VECTOR_MACROS_SVH
`define SNELL_REFRACTION_VECTOR_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define SNV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define SNV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset.
`define SNV_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/snv_pkg.sv =====
// Shared widths, stage numbers and types for the refraction pipeline.
// No dependencies.
package snv_pkg;

  localparam int IDX_W    = 16;  // index, unsigned Q4.12
  localparam int DOT_W    = 20;  // one floored component product, Q.16
  localparam int SUM_W    = 22;  // sum of three products
  localparam int COS_W    = 17;  // |cos|, Q.16, up to 1.0
  localparam int ETA_W    = 29;  // eta, Q.16, up to 2^28
  localparam int E2_W     = 42;  // floor(eta^2 / 2^16)
  localparam int SPLIT_W  = 21;  // low slice of e2 for the split multiply
  localparam int PP_W     = 38;  // partial product width
  localparam int PROD_W   = 59;  // eta^2 (1 - cos^2), Q.32
  localparam int K_W      = 33;  // k, Q.32
  localparam int ROOT_W   = 17;  // sqrt(k), Q.16
  localparam int EC_W     = 30;  // floor(eta*cos / 2^16)
  localparam int COEF_W   = 32;  // normal coefficient, signed Q.16

  localparam logic [COS_W-1:0] ONE_Q16 = COS_W'(65536);
  localparam logic [ETA_W-1:0] DIV_NUM = ETA_W'(268435456);   // 2^28
  localparam logic [K_W-1:0]   ONE_Q32 = K_W'(64'h1_0000_0000);

  // Register stage at which each value is valid (input register is stage 0).
  localparam int ST_DOT  = 2;
  localparam int ST_DIV  = ETA_W;        // one quotient bit per stage
  localparam int ST_ETA  = ST_DIV + 1;
  localparam int ST_SQ   = ST_ETA + 1;
  localparam int ST_PP   = ST_SQ + 1;
  localparam int ST_PROD = ST_PP + 1;
  localparam int ST_K    = ST_PROD + 1;
  localparam int ST_ROOT = ST_K + ROOT_W;  // one root bit per stage
  localparam int ST_COEF = ST_ROOT + 1;
  localparam int ST_MUL  = ST_COEF + 1;
  localparam int ST_OUT  = ST_MUL + 1;

  typedef struct packed {
    logic             leave;  // ray leaves the material
    logic [COS_W-1:0] mag;    // clamped |cos|
  } snv_cos_t;

endpackage

// ===== rtl/snv_delay.sv =====
// Shift line that carries payload alongside the pipeline stages.
// No dependencies.
module snv_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (adv) begin
      tap_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

// ===== rtl/snv_dot.sv =====
// Dot product of incident and normal, clamp, and entering/leaving decision.
// Depends on snv_pkg. Two register stages.
module snv_dot
  import snv_pkg::*;
#(
  parameter int VECTOR_BITS = 16
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic signed [VECTOR_BITS-1:0] inc [3],
  input  logic signed [VECTOR_BITS-1:0] nrm [3],
  output snv_cos_t                      cos_o
);

  localparam int SHIFT = 2 * VECTOR_BITS - 20;
  localparam logic signed [SUM_W-1:0] CLAMP_HI = SUM_W'(65536);
  localparam logic signed [SUM_W-1:0] CLAMP_LO = -SUM_W'(65536);

  logic signed [2*VECTOR_BITS-1:0] full [3];
  logic signed [DOT_W-1:0]         part_r [3];
  logic signed [SUM_W-1:0]         sum;
  logic signed [SUM_W-1:0]         neg;
  snv_cos_t                        cos_nxt;
  snv_cos_t                        cos_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full[i] = inc[i] * nrm[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        part_r[i] <= DOT_W'(full[i] >>> SHIFT);
      end
    end
  end

  // cos = -dot; a positive dot means the ray is leaving, so take |cos|
  always_comb begin
    sum = SUM_W'(part_r[0]) + SUM_W'(part_r[1]) + SUM_W'(part_r[2]);
    neg = -sum;
    cos_nxt.leave = (sum > 0);
    if (sum > CLAMP_HI || sum < CLAMP_LO) begin
      cos_nxt.mag = ONE_Q16;
    end else if (sum > 0) begin
      cos_nxt.mag = sum[COS_W-1:0];
    end else begin
      cos_nxt.mag = neg[COS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_r <= cos_nxt;
    end
  end

  assign cos_o = cos_r;

endmodule

// ===== rtl/snv_recip.sv =====
// Pipelined restoring divider: round(2^28 / index), one quotient bit per stage.
// Depends on snv_pkg.
module snv_recip
  import snv_pkg::*;
(
  input  logic             clk,
  input  logic             adv,
  input  logic [IDX_W-1:0] idx,
  output logic [ETA_W-1:0] quot
);

  logic [IDX_W-1:0] rem_r [ETA_W];
  logic [IDX_W-1:0] den_r [ETA_W];
  logic [ETA_W-1:0] num_r [ETA_W];
  logic [ETA_W-1:0] q_r   [ETA_W];

  for (genvar j = 0; j < ETA_W; j++) begin : g_stage
    logic [IDX_W-1:0] rem_p;
    logic [IDX_W-1:0] den_p;
    logic [ETA_W-1:0] num_p;
    logic [ETA_W-1:0] q_p;
    logic [IDX_W:0]   trial;

    if (j == 0) begin : g_first
      // zero index divides by one LSB; add half the divisor to round
      assign rem_p = '0;
      assign den_p = (idx == '0) ? IDX_W'(1) : idx;
      assign num_p = DIV_NUM + ETA_W'(idx >> 1);
      assign q_p   = '0;
    end else begin : g_rest
      assign rem_p = rem_r[j-1];
      assign den_p = den_r[j-1];
      assign num_p = num_r[j-1];
      assign q_p   = q_r[j-1];
    end

    assign trial = {rem_p, num_p[ETA_W-1]};

    always_ff @(posedge clk) begin
      if (adv) begin
        if (trial >= {1'b0, den_p}) begin
          rem_r[j] <= IDX_W'(trial - {1'b0, den_p});
          q_r[j]   <= {q_p[ETA_W-2:0], 1'b1};
        end else begin
          rem_r[j] <= trial[IDX_W-1:0];
          q_r[j]   <= {q_p[ETA_W-2:0], 1'b0};
        end
        num_r[j] <= {num_p[ETA_W-2:0], 1'b0};
        den_r[j] <= den_p;
      end
    end
  end

  assign quot = q_r[ETA_W-1];

endmodule

// ===== rtl/snv_isqrt.sv =====
// Pipelined floor square root of a Q.32 value, one root bit per stage.
// Depends on snv_pkg.
module snv_isqrt
  import snv_pkg::*;
(
  input  logic              clk,
  input  logic              adv,
  input  logic [K_W-1:0]    rad,
  output logic [ROOT_W-1:0] root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic [REM_W-1:0]  rem_p;
    logic [RAD_W-1:0]  rad_p;
    logic [ROOT_W-1:0] root_p;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;

    if (j == 0) begin : g_first
      assign rem_p  = '0;
      assign rad_p  = RAD_W'(rad);
      assign root_p = '0;
    end else begin : g_rest
      assign rem_p  = rem_r[j-1];
      assign rad_p  = rad_r[j-1];
      assign root_p = root_r[j-1];
    end

    assign cur   = {rem_p[REM_W-3:0], rad_p[RAD_W-1:RAD_W-2]};
    assign trial = REM_W'({root_p, 2'b01});

    always_ff @(posedge clk) begin
      if (adv) begin
        if (cur >= trial) begin
          rem_r[j]  <= cur - trial;
          root_r[j] <= {root_p[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[j]  <= cur;
          root_r[j] <= {root_p[ROOT_W-2:0], 1'b0};
        end
        rad_r[j] <= {rad_p[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

// ===== rtl/snell_refraction_vector.sv =====
// Top level of the Snell refraction pipeline.
// Depends on snv_pkg, snv_delay, snv_dot, snv_recip, snv_isqrt.
//
//   channel  dir  handshake           word
//   in_      in   in_valid/in_stall   incident xyz, normal xyz, index_ratio
//   out_     out  out_valid/out_stall refracted xyz, total_reflection
//
// One word enters per cycle while in_stall is low, and it shows on the output
// once it has passed register stages 0 to ST_OUT:
// the 29-stage reciprocal divider and the 17-stage square root set the depth.
// rst_n is synchronous; it clears the valid bits only, payload is not reset.
// A stalled output word holds the whole pipeline; bubbles are not squeezed out.
// in_stall is high while the output word waits and during reset.
module snell_refraction_vector
  import snv_pkg::*;
#(
  parameter int VECTOR_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VECTOR_BITS-1:0] in_incident_x,
  input  logic signed [VECTOR_BITS-1:0] in_incident_y,
  input  logic signed [VECTOR_BITS-1:0] in_incident_z,
  input  logic signed [VECTOR_BITS-1:0] in_normal_x,
  input  logic signed [VECTOR_BITS-1:0] in_normal_y,
  input  logic signed [VECTOR_BITS-1:0] in_normal_z,
  input  logic        [IDX_W-1:0]       in_index_ratio,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VECTOR_BITS-1:0] out_refracted_x,
  output logic signed [VECTOR_BITS-1:0] out_refracted_y,
  output logic signed [VECTOR_BITS-1:0] out_refracted_z,
  output logic                          out_total_reflection
);

  localparam int W     = VECTOR_BITS;
  localparam int MI_W  = W + ETA_W + 1;
  localparam int MN_W  = W + COEF_W;
  localparam int ACC_W = W + COEF_W + 1;

  logic [ST_OUT:0] vld_r;

  // advance every stage unless the output word is held
  logic adv;
  assign adv      = !vld_r[ST_OUT] || !out_stall;
  assign in_stall = !rst_n || !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[ST_OUT-1:0], in_valid};
    end
  end

  // Stage 0: input register
  logic signed [W-1:0] inc_r [3];
  logic signed [W-1:0] nrm_r [3];
  logic [IDX_W-1:0]    idx_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      inc_r[0] <= in_incident_x;
      inc_r[1] <= in_incident_y;
      inc_r[2] <= in_incident_z;
      nrm_r[0] <= in_normal_x;
      nrm_r[1] <= in_normal_y;
      nrm_r[2] <= in_normal_z;
      idx_r    <= in_index_ratio;
    end
  end

  // Stages 1-2: dot product, clamp, entering or leaving
  snv_cos_t cos_dot;
  snv_cos_t cos_div;

  snv_dot #(.VECTOR_BITS(W)) u_dot (
    .clk  (clk),
    .adv  (adv),
    .inc  (inc_r),
    .nrm  (nrm_r),
    .cos_o(cos_dot)
  );

  snv_delay #(.WIDTH($bits(snv_cos_t)), .DEPTH(ST_DIV - ST_DOT)) u_dly_cos (
    .clk (clk),
    .adv (adv),
    .din (cos_dot),
    .dout(cos_div)
  );

  // Stages 1-29: reciprocal of the index for entering rays
  logic [ETA_W-1:0] quot;
  logic [IDX_W-1:0] idx_div;

  snv_recip u_recip (
    .clk (clk),
    .adv (adv),
    .idx (idx_r),
    .quot(quot)
  );

  snv_delay #(.WIDTH(IDX_W), .DEPTH(ST_DIV)) u_dly_idx (
    .clk (clk),
    .adv (adv),
    .din (idx_r),
    .dout(idx_div)
  );

  // Stage 30: pick eta; leaving rays use the index itself, shifted to Q.16
  logic [ETA_W-1:0] eta30_r;
  logic [COS_W-1:0] cos30_r;
  logic             leave30_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      eta30_r   <= cos_div.leave ? ETA_W'({idx_div, 4'b0000}) : quot;
      cos30_r   <= cos_div.mag;
      leave30_r <= cos_div.leave;
    end
  end

  // Stage 31: squares and eta*cos
  logic [2*ETA_W-1:0]       esq;
  logic [ETA_W+COS_W-1:0]   ecp;
  logic [2*COS_W-2:0]       csq;
  logic [E2_W-1:0]          e2_r;
  logic [EC_W-1:0]          ec31_r;
  logic [COS_W-1:0]         s2_r;

  assign esq = eta30_r * eta30_r;
  assign ecp = eta30_r * cos30_r;
  assign csq = (2*COS_W-1)'(cos30_r * cos30_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_r   <= esq[2*ETA_W-1:16];
      ec31_r <= ecp[ETA_W+COS_W-1:16];
      s2_r   <= ONE_Q16 - csq[2*COS_W-2:16];
    end
  end

  // Stage 32: eta^2 (1 - cos^2) as two partial products
  logic [PP_W-1:0] plo_r;
  logic [PP_W-1:0] phi_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      plo_r <= PP_W'(e2_r[SPLIT_W-1:0] * s2_r);
      phi_r <= PP_W'(e2_r[E2_W-1:SPLIT_W] * s2_r);
    end
  end

  // Stage 33: join the partial products
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= PROD_W'({phi_r, {SPLIT_W{1'b0}}}) + PROD_W'(plo_r);
    end
  end

  // Stage 34: k = 1 - eta^2 (1 - cos^2); negative k is total reflection
  logic [K_W-1:0] k_r;
  logic           tir34_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      tir34_r <= (prod_r > PROD_W'(ONE_Q32));
      k_r     <= ONE_Q32 - prod_r[K_W-1:0];
    end
  end

  // Stages 35-51: sqrt(k)
  logic [ROOT_W-1:0] sq;

  snv_isqrt u_isqrt (
    .clk (clk),
    .adv (adv),
    .rad (k_r),
    .root(sq)
  );

  logic [EC_W-1:0] ec51;
  logic            leave51;

  snv_delay #(.WIDTH(EC_W), .DEPTH(ST_ROOT - ST_SQ)) u_dly_ec (
    .clk (clk),
    .adv (adv),
    .din (ec31_r),
    .dout(ec51)
  );

  snv_delay #(.WIDTH(1), .DEPTH(ST_ROOT - ST_ETA)) u_dly_leave (
    .clk (clk),
    .adv (adv),
    .din (leave30_r),
    .dout(leave51)
  );

  // Stage 52: normal coefficient; negate it instead of flipping the normal
  logic signed [COEF_W-1:0] diff;
  logic signed [COEF_W-1:0] coef_r;

  assign diff = $signed(COEF_W'(ec51)) - $signed(COEF_W'(sq));

  always_ff @(posedge clk) begin
    if (adv) begin
      coef_r <= leave51 ? -diff : diff;
    end
  end

  logic [6*W-1:0]      vec52;
  logic [ETA_W-1:0]    eta52;
  logic signed [W-1:0] inc52 [3];
  logic signed [W-1:0] nrm52 [3];

  snv_delay #(.WIDTH(6*W), .DEPTH(ST_COEF)) u_dly_vec (
    .clk (clk),
    .adv (adv),
    .din ({inc_r[0], inc_r[1], inc_r[2], nrm_r[0], nrm_r[1], nrm_r[2]}),
    .dout(vec52)
  );

  snv_delay #(.WIDTH(ETA_W), .DEPTH(ST_COEF - ST_ETA)) u_dly_eta (
    .clk (clk),
    .adv (adv),
    .din (eta30_r),
    .dout(eta52)
  );

  assign inc52[0] = vec52[6*W-1:5*W];
  assign inc52[1] = vec52[5*W-1:4*W];
  assign inc52[2] = vec52[4*W-1:3*W];
  assign nrm52[0] = vec52[3*W-1:2*W];
  assign nrm52[1] = vec52[2*W-1:W];
  assign nrm52[2] = vec52[W-1:0];

  // Stage 53: I*eta and n*coef per component
  logic signed [MI_W-1:0] mi_r [3];
  logic signed [MN_W-1:0] mn_r [3];
  logic                   tir53;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mi_r[i] <= inc52[i] * $signed({1'b0, eta52});
        mn_r[i] <= nrm52[i] * coef_r;
      end
    end
  end

  snv_delay #(.WIDTH(1), .DEPTH(ST_MUL - ST_K)) u_dly_tir (
    .clk (clk),
    .adv (adv),
    .din (tir34_r),
    .dout(tir53)
  );

  // Stage 54: sum, round half up to Q2.F, saturate; zero on total reflection
  logic signed [ACC_W-1:0] acc [3];
  logic signed [ACC_W-1:0] rnd [3];
  logic signed [W-1:0]     res_nxt [3];
  logic signed [W-1:0]     res_r [3];
  logic                    tir_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC_W'(mi_r[i]) + ACC_W'(mn_r[i]) + ACC_W'(32768);
      rnd[i] = acc[i] >>> 16;
      if (tir53) begin
        res_nxt[i] = '0;
      end else if ((&rnd[i][ACC_W-1:W-1]) || !(|rnd[i][ACC_W-1:W-1])) begin
        res_nxt[i] = rnd[i][W-1:0];
      end else if (rnd[i][ACC_W-1]) begin
        res_nxt[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        res_nxt[i] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      tir_r <= tir53;
    end
  end

  assign out_valid            = vld_r[ST_OUT];
  assign out_refracted_x      = res_r[0];
  assign out_refracted_y      = res_r[1];
  assign out_refracted_z      = res_r[2];
  assign out_total_reflection = tir_r;

endmodule

// ===== rtl/snv_checker.sv =====
// Port-level checks for the refraction block, bound to its top level.
// Depends on snell_refraction_vector_macros.svh.
`include "snell_refraction_vector_macros.svh"

module snv_checker #(
  parameter int VECTOR_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [VECTOR_BITS-1:0] out_refracted_x,
  input logic [VECTOR_BITS-1:0] out_refracted_y,
  input logic [VECTOR_BITS-1:0] out_refracted_z,
  input logic                   out_total_reflection
);

  // total reflection always comes with a zero vector
  `SNV_ASSERT_NOW(a_tir_zero, out_valid && out_total_reflection, out_refracted_x == '0 && out_refracted_y == '0 && out_refracted_z == '0, "total reflection with nonzero vector")

  // input back-pressure only while the output word is held
  `SNV_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall, "input stalled without output stall")

  // held output word keeps its payload
  `SNV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_refracted_x) && $stable(out_refracted_y) && $stable(out_refracted_z) && $stable(out_total_reflection), "held output word changed")

  // reset empties the pipeline
  `SNV_ASSERT_RST(a_rst_empty, !rst_n, !out_valid, "output valid right after reset")

endmodule

bind snell_refraction_vector snv_checker #(.VECTOR_BITS(VECTOR_BITS)) u_chk (.*);
